/* rtl/core/cli_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compressed integer decoder package
// Shared codes, constants and the record type that passes from the byte
// front end through the queue to the result back end.
// ----------------------------------------------------------------------------
package cli_pkg;

   // Command codes carried with each input word.
   localparam logic [1:0] CMD_UNSIGNED   = 2'd0;
   localparam logic [1:0] CMD_SIGNED     = 2'd1;
   localparam logic [1:0] CMD_TOKEN      = 2'd2;
   localparam logic [1:0] CMD_READ_EMPTY = 2'd3;

   // Encoded length of an item.
   localparam logic [1:0] FORM_ONE  = 2'd0;
   localparam logic [1:0] FORM_TWO  = 2'd1;
   localparam logic [1:0] FORM_FOUR = 2'd2;
   localparam logic [1:0] FORM_FIVE = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] REG_TYPEDEF_TAG  = 2'd0;
   localparam logic [1:0] REG_TYPEREF_TAG  = 2'd1;
   localparam logic [1:0] REG_TYPESPEC_TAG = 2'd2;
   localparam logic [1:0] REG_BASETYPE_TAG = 2'd3;

   localparam logic [31:0] TYPEDEF_TAG_RESET  = 32'h0200_0000;
   localparam logic [31:0] TYPEREF_TAG_RESET  = 32'h0100_0000;
   localparam logic [31:0] TYPESPEC_TAG_RESET = 32'h1B00_0000;
   localparam logic [31:0] BASETYPE_TAG_RESET = 32'h6400_0000;

   localparam logic [7:0] MASK_TWO_BYTE  = 8'h3F;
   localparam logic [7:0] MASK_FOUR_BYTE = 8'h1F;

   // Sign fill patterns for the shorter signed forms.
   localparam logic [31:0] SIGN_FILL_ONE  = 32'hFFFF_FFC0;
   localparam logic [31:0] SIGN_FILL_TWO  = 32'hFFFF_E000;
   localparam logic [31:0] SIGN_FILL_FOUR = 32'hF000_0000;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   // One finished item, or one error, handed from front to back.
   typedef struct packed {
      logic [31:0] acc;
      logic [1:0]  mode;
      logic [1:0]  form;
      logic        err;
   } item_rec_type;

endpackage

/* rtl/core/cli_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compressed integer decoder front end
// Accepts blob bytes, classifies the prefix and assembles each item.
// ----------------------------------------------------------------------------
module cli_front import cli_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_command,
   input  logic [7:0]   req_byte_value,
   input  logic         req_last_in_buffer,
   input  logic         q_ready,
   output logic         q_push,
   output item_rec_type q_rec
);

   logic [31:0] acc_ff,     acc_in;
   logic [2:0]  remain_ff,  remain_in;
   logic [1:0]  mode_ff,    mode_in;
   logic [1:0]  form_ff,    form_in;
   logic        discard_ff, discard_in;
   logic        fire;
   logic [7:0]  b;

   assign req_ready = q_ready;
   assign fire      = req_valid & req_ready;
   assign b         = req_byte_value;

   always_comb begin
      acc_in     = acc_ff;
      remain_in  = remain_ff;
      mode_in    = mode_ff;
      form_in    = form_ff;
      discard_in = discard_ff;
      q_push     = 1'b0;
      q_rec      = '{acc: '0, mode: mode_ff, form: form_ff, err: 1'b1};
      if (fire) begin
         if (req_command == CMD_READ_EMPTY) begin
            remain_in  = 3'd0;
            discard_in = 1'b0;
            q_push     = 1'b1;
         end else if (discard_ff) begin
            if (req_last_in_buffer) begin
               discard_in = 1'b0;
            end
         end else if (remain_ff != 3'd0) begin
            acc_in    = {acc_ff[23:0], b};
            remain_in = remain_ff - 3'd1;
            if (remain_ff == 3'd1) begin
               q_push = 1'b1;
               q_rec  = '{acc: acc_in, mode: mode_ff, form: form_ff, err: 1'b0};
            end else if (req_last_in_buffer) begin
               remain_in = 3'd0;
               q_push    = 1'b1;
            end
         end else begin
            mode_in = req_command;
            if (!b[7]) begin
               form_in = FORM_ONE;
               acc_in  = {24'd0, b};
               q_push  = 1'b1;
               q_rec   = '{acc: acc_in, mode: req_command, form: FORM_ONE, err: 1'b0};
            end else begin
               if (!b[6]) begin
                  form_in   = FORM_TWO;
                  acc_in    = {24'd0, b & MASK_TWO_BYTE};
                  remain_in = 3'd1;
               end else if (!b[5]) begin
                  form_in   = FORM_FOUR;
                  acc_in    = {24'd0, b & MASK_FOUR_BYTE};
                  remain_in = 3'd3;
               end else if (!b[4] || req_command == CMD_SIGNED) begin
                  form_in   = FORM_FIVE;
                  acc_in    = 32'd0;
                  remain_in = 3'd4;
               end else begin
                  // Unknown prefix: report it, then drop bytes to buffer end.
                  form_in    = FORM_ONE;
                  acc_in     = 32'd0;
                  discard_in = ~req_last_in_buffer;
                  q_push     = 1'b1;
               end
               if (remain_in != 3'd0 && req_last_in_buffer) begin
                  remain_in = 3'd0;
                  q_push    = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         remain_ff  <= '0;
         mode_ff    <= CMD_UNSIGNED;
         form_ff    <= FORM_ONE;
         discard_ff <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         remain_ff  <= remain_in;
         mode_ff    <= mode_in;
         form_ff    <= form_in;
         discard_ff <= discard_in;
      end
   end

   // Discarding only follows an unknown prefix, which leaves no item open.
   assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (remain_ff == 3'd0))
      else $error("front: discarding while an item is open");

   // An item never needs more than four trailing bytes.
   assert property (@(posedge clock) disable iff (reset)
      remain_ff <= 3'd4)
      else $error("front: byte count out of range");

endmodule

/* rtl/core/cli_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compressed integer decoder record queue
// Two-entry queue that decouples the byte front end from the back end.
// ----------------------------------------------------------------------------
module cli_queue import cli_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  item_rec_type push_rec,
   output logic         push_ready,
   input  logic         pop,
   output logic         pop_valid,
   output item_rec_type pop_rec
);

   item_rec_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff,  count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_rec    = entry_ff[rd_ptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue: occupancy above depth");

   // A record offered while the queue is full would be lost.
   assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("queue: push while full");

endmodule

/* rtl/core/cli_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compressed integer decoder back end
// Holds the tag registers, finishes each record and drives the result word.
// ----------------------------------------------------------------------------
module cli_back import cli_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data,
   input  logic         q_valid,
   input  item_rec_type q_rec,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [31:0]  rsp_value,
   output logic         rsp_error,
   output logic         rsp_sticky_error
);

   logic [31:0] tag_ff [4];
   logic        seen_ff,  seen_in;
   logic        valid_ff, valid_in;
   logic [31:0] value_ff, value_in;
   logic        error_ff, error_in;
   logic        sticky_ff, sticky_in;
   logic [31:0] a;
   logic [31:0] signed_val;

   assign csr_ready = 1'b1;
   assign q_pop     = q_valid & (~valid_ff | rsp_ready);
   assign a         = q_rec.acc;

   always_comb begin
      if (q_rec.form == FORM_FIVE) begin
         signed_val = a;
      end else if (!a[0]) begin
         signed_val = a >> 1;
      end else begin
         unique case (q_rec.form)
            FORM_ONE: signed_val = (a >> 1) | SIGN_FILL_ONE;
            FORM_TWO: signed_val = (a >> 1) | SIGN_FILL_TWO;
            default:  signed_val = (a >> 1) | SIGN_FILL_FOUR;
         endcase
      end
   end

   always_comb begin
      seen_in   = seen_ff;
      valid_in  = valid_ff & ~rsp_ready;
      value_in  = value_ff;
      error_in  = error_ff;
      sticky_in = sticky_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         if (q_rec.err) begin
            seen_in   = 1'b1;
            value_in  = 32'd0;
            error_in  = 1'b1;
            sticky_in = 1'b1;
         end else begin
            error_in  = 1'b0;
            sticky_in = seen_ff;
            unique case (q_rec.mode)
               CMD_SIGNED: value_in = signed_val;
               CMD_TOKEN:  value_in = seen_ff ? 32'd0 : ((a >> 2) | tag_ff[a[1:0]]);
               default:    value_in = a;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         valid_ff <= 1'b0;
         tag_ff[REG_TYPEDEF_TAG]  <= TYPEDEF_TAG_RESET;
         tag_ff[REG_TYPEREF_TAG]  <= TYPEREF_TAG_RESET;
         tag_ff[REG_TYPESPEC_TAG] <= TYPESPEC_TAG_RESET;
         tag_ff[REG_BASETYPE_TAG] <= BASETYPE_TAG_RESET;
      end else begin
         seen_ff  <= seen_in;
         valid_ff <= valid_in;
         if (csr_valid && csr_ready) begin
            tag_ff[csr_index] <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      error_ff  <= error_in;
      sticky_ff <= sticky_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_value        = value_ff;
   assign rsp_error        = error_ff;
   assign rsp_sticky_error = sticky_ff;

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && error_ff) |-> (sticky_ff && value_ff == 32'd0))
      else $error("back: error word without sticky flag or with nonzero value");

   // Only reset clears the sticky error.
   assert property (@(posedge clock) disable iff (reset)
      $past(seen_ff) && !$past(reset) |-> seen_ff)
      else $error("back: sticky error cleared");

endmodule

/* rtl/core/cli_compressed_integer_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compressed integer decoder unit
// Decodes ECMA-335 style compressed integers, signed values and coded
// tokens from a byte stream, one byte per word.
// ----------------------------------------------------------------------------
// The unit takes one blob byte per cycle on the req_ channel and returns one
// word on the rsp_ channel for every item that ends, errors included. The
// command sent with an item's first byte selects unsigned, signed or token
// decoding; the bytes that follow ignore their command unless it reports an
// empty buffer. A result passes from the item's final byte through the
// two-entry record queue and then the output register. With rsp_ready held
// high the unit sustains one byte per cycle; when the output stalls, the
// queue absorbs two more finished items before req_ready drops. Tag
// registers are written through the csr_ channel, which is always ready,
// and must only change while the unit is idle. The sticky error flag is
// cleared by reset alone and, once set, forces token values to zero.
// ----------------------------------------------------------------------------
module cli_compressed_integer_decoder_unit import cli_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Byte input channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_byte_value,
   input  logic        req_last_in_buffer,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value,
   output logic        rsp_error,
   output logic        rsp_sticky_error,
   // Tag register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   // Records flow from the front end into the queue and out to the back end.
   item_rec_type push_rec;
   item_rec_type pop_rec;
   logic         push;
   logic         push_ready;
   logic         pop;
   logic         pop_valid;

   // The front end tracks the open item and classifies every byte.
   cli_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_byte_value     (req_byte_value),
      .req_last_in_buffer (req_last_in_buffer),
      .q_ready            (push_ready),
      .q_push             (push),
      .q_rec              (push_rec)
   );

   // The queue lets the front end keep taking bytes while a result waits.
   cli_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_rec    (pop_rec)
   );

   // The back end applies sign extension, token tags and the sticky error.
   cli_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .q_valid          (pop_valid),
      .q_rec            (pop_rec),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_error        (rsp_error),
      .rsp_sticky_error (rsp_sticky_error)
   );

endmodule
